// ===== design/exalubr_pkg.sv =====
// Shared types and codes for the execute stage ALU / branch unit.
// No dependencies.
`default_nettype none

package exalubr_pkg;

	localparam logic [5:0] JUMP_REG_OPCODE = 6'b010011;
	localparam int unsigned OFFSET_SHIFT = 2;

	typedef enum logic [3:0] {
		ACT_INVALID = 4'd0,
		ACT_SYSCALL = 4'd1,
		ACT_ADD     = 4'd2,
		ACT_SLT     = 4'd3,
		ACT_SLTU    = 4'd4,
		ACT_NOR     = 4'd5,
		ACT_AND     = 4'd6,
		ACT_OR      = 4'd7,
		ACT_XOR     = 4'd8,
		ACT_SLL     = 4'd9,
		ACT_SRL     = 4'd10,
		ACT_SUB     = 4'd11,
		ACT_SRA     = 4'd12
	} action_t;

	typedef enum logic [2:0] {
		BR_EQ  = 3'd0,
		BR_NE  = 3'd1,
		BR_GE  = 3'd2,
		BR_GEU = 3'd3,
		BR_LT  = 3'd4,
		BR_LTU = 3'd5
	} branch_cond_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_MEM_INVALID = 2'd1,
		ST_INVALID     = 2'd2,
		ST_SYSCALL     = 2'd3
	} status_t;

	// one decoded instruction as held in the input register
	typedef struct packed {
		logic [3:0]  action;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic        cond_branch;
		logic        is_jump;
		logic [2:0]  branch_cond;
		logic [31:0] pc;
		logic [31:0] next_pc;
		logic [5:0]  major_opcode;
		logic [15:0] branch_offset;
		logic        mem_op_invalid;
	} exec_req_t;

	typedef struct packed {
		logic [31:0] alu_value;
		logic        flow_taken;
		logic [31:0] flow_pc;
		logic [1:0]  status;
	} exec_rsp_t;

endpackage

`default_nettype wire

// ===== design/execute_stage_alu_branch_unit.sv =====
// Execute stage top level: input register, ALU and branch resolve, result register.
// Depends on exalubr_pkg.
`default_nettype none

// Execute stage ALU / branch unit. Takes one request per clock on the in
// channel while in_stall is low and returns one result per request on the
// out channel, in order. The input register loads on acceptance, the result
// register when the request moves on (out_stall can hold it); out_valid is
// the result register's valid. The sustained rate is one request per cycle
// as long as out_stall stays low. The ALU, the branch compare and the target
// adder all sit in the single logic stage between the two registers. Shifts,
// set-less-than and subtract use operand_b as the left operand and operand_a
// as the amount or subtrahend; shift amounts use operand_a[4:0]. A halting
// request (bad memory op, invalid action, syscall) returns status only, with
// alu_value 0, flow not taken and flow_pc equal to pc.
module execute_stage_alu_branch_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  action,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	input  wire logic        cond_branch,
	input  wire logic        is_jump,
	input  wire logic [2:0]  branch_cond,
	input  wire logic [31:0] pc,
	input  wire logic [31:0] next_pc,
	input  wire logic [5:0]  major_opcode,
	input  wire logic signed [15:0] branch_offset,
	input  wire logic        mem_op_invalid,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      alu_value,
	output logic             flow_taken,
	output logic [31:0]      flow_pc,
	output logic [1:0]       status
);

	logic                    valid_s1;
	exalubr_pkg::exec_req_t  req_s1;
	logic                    valid_s2;
	exalubr_pkg::exec_rsp_t  rsp_s2;
	exalubr_pkg::exec_rsp_t  rsp_d;

	logic                    load_s2;
	logic                    load_s1;

	assign load_s2  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			req_s1.action         <= action;
			req_s1.operand_a      <= operand_a;
			req_s1.operand_b      <= operand_b;
			req_s1.cond_branch    <= cond_branch;
			req_s1.is_jump        <= is_jump;
			req_s1.branch_cond    <= branch_cond;
			req_s1.pc             <= pc;
			req_s1.next_pc        <= next_pc;
			req_s1.major_opcode   <= major_opcode;
			req_s1.branch_offset  <= branch_offset;
			req_s1.mem_op_invalid <= mem_op_invalid;
		end
	end

	// ALU, branch compare and target
	logic [4:0]  shamt;
	logic [31:0] a;
	logic [31:0] b;
	logic [31:0] alu_val;
	logic        cond_met;
	logic        taken;
	logic [31:0] offset_ext;
	logic [1:0]  status_d;

	assign a     = req_s1.operand_a;
	assign b     = req_s1.operand_b;
	assign shamt = a[4:0];
	assign offset_ext = {{16{req_s1.branch_offset[15]}}, req_s1.branch_offset}
		<< exalubr_pkg::OFFSET_SHIFT;

	always_comb begin
		case (req_s1.action)
			exalubr_pkg::ACT_ADD:  alu_val = a + b;
			exalubr_pkg::ACT_SLT:  alu_val = {31'd0, $signed(b) < $signed(a)};
			exalubr_pkg::ACT_SLTU: alu_val = {31'd0, b < a};
			exalubr_pkg::ACT_NOR:  alu_val = ~(a | b);
			exalubr_pkg::ACT_AND:  alu_val = a & b;
			exalubr_pkg::ACT_OR:   alu_val = a | b;
			exalubr_pkg::ACT_XOR:  alu_val = a ^ b;
			exalubr_pkg::ACT_SLL:  alu_val = b << shamt;
			exalubr_pkg::ACT_SRL:  alu_val = b >> shamt;
			exalubr_pkg::ACT_SUB:  alu_val = b - a;
			exalubr_pkg::ACT_SRA:  alu_val = 32'($signed(b) >>> shamt);
			default:               alu_val = 32'd0;
		endcase
	end

	always_comb begin
		case (req_s1.branch_cond)
			exalubr_pkg::BR_EQ:  cond_met = (a == b);
			exalubr_pkg::BR_NE:  cond_met = (a != b);
			exalubr_pkg::BR_GE:  cond_met = !($signed(a) < $signed(b));
			exalubr_pkg::BR_GEU: cond_met = (a >= b);
			exalubr_pkg::BR_LT:  cond_met = ($signed(a) < $signed(b));
			exalubr_pkg::BR_LTU: cond_met = (a < b);
			default:             cond_met = 1'b0;
		endcase
	end

	always_comb begin
		if (req_s1.mem_op_invalid) begin
			status_d = exalubr_pkg::ST_MEM_INVALID;
		end else if (req_s1.action == exalubr_pkg::ACT_INVALID) begin
			status_d = exalubr_pkg::ST_INVALID;
		end else if (req_s1.action == exalubr_pkg::ACT_SYSCALL) begin
			status_d = exalubr_pkg::ST_SYSCALL;
		end else begin
			status_d = exalubr_pkg::ST_OK;
		end
	end

	// a conditional branch wins over is_jump
	assign taken = (status_d == exalubr_pkg::ST_OK) &&
		(req_s1.cond_branch ? cond_met : req_s1.is_jump);

	always_comb begin
		rsp_d.status     = status_d;
		rsp_d.flow_taken = taken;
		rsp_d.alu_value  = (status_d == exalubr_pkg::ST_OK) ? alu_val : 32'd0;
		if (!taken) begin
			rsp_d.flow_pc = req_s1.pc;
		end else if (req_s1.major_opcode == exalubr_pkg::JUMP_REG_OPCODE) begin
			rsp_d.flow_pc = req_s1.next_pc;
		end else begin
			rsp_d.flow_pc = req_s1.pc + offset_ext;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign out_valid  = valid_s2;
	assign alu_value  = rsp_s2.alu_value;
	assign flow_taken = rsp_s2.flow_taken;
	assign flow_pc    = rsp_s2.flow_pc;
	assign status     = rsp_s2.status;

	// a halted request never carries a result or a taken flow change
	a_halt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != exalubr_pkg::ST_OK) |-> !flow_taken && (alu_value == 32'd0))
		else $error("halting result carries alu value or taken flow");

	// input side stalls only when both stages are full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with free pipeline slot");

	// a request in s1 that moves on shows up as a result next cycle
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && load_s2 |=> out_valid)
		else $error("request lost between stages");

	// a stalled s1 request keeps its payload
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && in_stall |=> valid_s1 && $stable(req_s1))
		else $error("stalled input register changed");

endmodule

`default_nettype wire

// ===== sim/tb_execute_stage_alu_branch_unit.sv =====
// Self-checking bench for the execute stage ALU / branch unit.
// Depends on exalubr_pkg and execute_stage_alu_branch_unit; predicts results internally.
`timescale 1ns / 1ps

module tb_execute_stage_alu_branch_unit;

	localparam int RANDOM_REQUESTS = 1100;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int TAIL_CYCLES     = 8;

	// Holds the predicted results of accepted requests, oldest first.
	class result_ledger;
		exalubr_pkg::exec_rsp_t expected_results[$];
		int        mismatches;
		int        checked;

		function new();
			mismatches = 0;
			checked    = 0;
		endfunction

		function exalubr_pkg::exec_rsp_t resolve_instruction(exalubr_pkg::exec_req_t r);
			exalubr_pkg::exec_rsp_t e;
			logic [4:0]  sh;
			logic [31:0] a;
			logic [31:0] b;
			logic [31:0] offset_bytes;
			logic        taken;
			a = r.operand_a;
			b = r.operand_b;
			sh = a[4:0];
			taken = 1'b0;
			e.alu_value  = '0;
			e.flow_taken = 1'b0;
			e.flow_pc    = r.pc;
			e.status     = exalubr_pkg::ST_OK;
			if (r.mem_op_invalid)
				e.status = exalubr_pkg::ST_MEM_INVALID;
			else if (r.action == exalubr_pkg::ACT_INVALID)
				e.status = exalubr_pkg::ST_INVALID;
			else if (r.action == exalubr_pkg::ACT_SYSCALL)
				e.status = exalubr_pkg::ST_SYSCALL;
			if (e.status == exalubr_pkg::ST_OK) begin
				// B is the left operand for set-less-than, subtract and shifts
				case (r.action)
					exalubr_pkg::ACT_ADD:  e.alu_value = a + b;
					exalubr_pkg::ACT_SLT:  e.alu_value = {31'd0, $signed(b) < $signed(a)};
					exalubr_pkg::ACT_SLTU: e.alu_value = {31'd0, b < a};
					exalubr_pkg::ACT_NOR:  e.alu_value = ~(a | b);
					exalubr_pkg::ACT_AND:  e.alu_value = a & b;
					exalubr_pkg::ACT_OR:   e.alu_value = a | b;
					exalubr_pkg::ACT_XOR:  e.alu_value = a ^ b;
					exalubr_pkg::ACT_SLL:  e.alu_value = b << sh;
					exalubr_pkg::ACT_SRL:  e.alu_value = b >> sh;
					exalubr_pkg::ACT_SUB:  e.alu_value = b - a;
					exalubr_pkg::ACT_SRA:  e.alu_value = $unsigned($signed(b) >>> sh);
					default:               e.alu_value = '0;
				endcase
				if (r.cond_branch) begin
					case (r.branch_cond)
						exalubr_pkg::BR_EQ:  taken = (a == b);
						exalubr_pkg::BR_NE:  taken = (a != b);
						exalubr_pkg::BR_GE:  taken = !($signed(a) < $signed(b));
						exalubr_pkg::BR_GEU: taken = (a >= b);
						exalubr_pkg::BR_LT:  taken = ($signed(a) < $signed(b));
						exalubr_pkg::BR_LTU: taken = (a < b);
						default:             taken = 1'b0;
					endcase
				end else if (r.is_jump) begin
					taken = 1'b1;
				end
				if (taken) begin
					offset_bytes = {{16{r.branch_offset[15]}}, r.branch_offset}
						<< exalubr_pkg::OFFSET_SHIFT;
					e.flow_pc = (r.major_opcode == exalubr_pkg::JUMP_REG_OPCODE) ?
						r.next_pc : r.pc + offset_bytes;
				end
				e.flow_taken = taken;
			end
			return e;
		endfunction

		function void note_request(exalubr_pkg::exec_req_t r);
			expected_results.push_back(resolve_instruction(r));
		endfunction

		function void check_result(exalubr_pkg::exec_rsp_t got);
			exalubr_pkg::exec_rsp_t e;
			checked++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d with no request due: alu=%h tk=%b pc=%h st=%0d",
						checked, got.alu_value, got.flow_taken, got.flow_pc, got.status);
				return;
			end
			e = expected_results.pop_front();
			if (got.alu_value !== e.alu_value || got.flow_taken !== e.flow_taken ||
			    got.flow_pc !== e.flow_pc || got.status !== e.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: exp alu=%h tk=%b pc=%h st=%0d, got %h %b %h %0d",
						checked, e.alu_value, e.flow_taken, e.flow_pc, e.status,
						got.alu_value, got.flow_taken, got.flow_pc, got.status);
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  action;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	logic        cond_branch;
	logic        is_jump;
	logic [2:0]  branch_cond;
	logic [31:0] pc;
	logic [31:0] next_pc;
	logic [5:0]  major_opcode;
	logic signed [15:0] branch_offset;
	logic        mem_op_invalid;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] alu_value;
	logic        flow_taken;
	logic [31:0] flow_pc;
	logic [1:0]  status;

	result_ledger ledger;
	exalubr_pkg::exec_rsp_t seen;
	int           requests_sent = 0;
	int           drains = 0;
	int           cycles = 0;
	int           burst_left = 0;

	execute_stage_alu_branch_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.operand_a      (operand_a),
		.operand_b      (operand_b),
		.cond_branch    (cond_branch),
		.is_jump        (is_jump),
		.branch_cond    (branch_cond),
		.pc             (pc),
		.next_pc        (next_pc),
		.major_opcode   (major_opcode),
		.branch_offset  (branch_offset),
		.mem_op_invalid (mem_op_invalid),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.alu_value      (alu_value),
		.flow_taken     (flow_taken),
		.flow_pc        (flow_pc),
		.status         (status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles, ledger.pending());
			$display("execute_stage_alu_branch_unit: mismatch");
			$finish;
		end
	end

	// Receiver: checks accepted results and stalls in changing modes
	// (free running, random, long stall runs).
	int  stall_mode = 0;
	int  mode_left = 0;
	int  run_left = 0;
	logic stall_on = 1'b0;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.alu_value  = alu_value;
			seen.flow_taken = flow_taken;
			seen.flow_pc    = flow_pc;
			seen.status     = status;
			ledger.check_result(seen);
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left  = $urandom_range(20, 200);
		end
		mode_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 99) < 30);
			default: begin
				if (run_left == 0) begin
					stall_on = !stall_on;
					run_left = stall_on ? $urandom_range(1, 8) : $urandom_range(1, 4);
				end
				run_left--;
				out_stall <= stall_on;
			end
		endcase
	end

	// Call right after a rising edge; returns right after the accepting edge.
	task automatic send_request(input exalubr_pkg::exec_req_t r);
		action         <= r.action;
		operand_a      <= r.operand_a;
		operand_b      <= r.operand_b;
		cond_branch    <= r.cond_branch;
		is_jump        <= r.is_jump;
		branch_cond    <= r.branch_cond;
		pc             <= r.pc;
		next_pc        <= r.next_pc;
		major_opcode   <= r.major_opcode;
		branch_offset  <= r.branch_offset;
		mem_op_invalid <= r.mem_op_invalid;
		in_valid       <= 1'b1;
		do @(posedge clk); while (in_stall);
		ledger.note_request(r);
		requests_sent++;
	endtask

	task automatic idle_cycles(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Sender side burst/gap pattern around each request.
	task automatic issue(input exalubr_pkg::exec_req_t r);
		if (burst_left == 0) begin
			idle_cycles($urandom_range(1, 8));
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		send_request(r);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
		drains++;
	endtask

	function automatic exalubr_pkg::exec_req_t instr(input logic [3:0] act,
			input logic [31:0] a, input logic [31:0] b, input logic br, input logic jmp,
			input logic [2:0] cond, input logic [31:0] cur_pc, input logic [31:0] npc,
			input logic [5:0] opc, input logic [15:0] off, input logic mem_bad);
		exalubr_pkg::exec_req_t r;
		r.action         = act;
		r.operand_a      = a;
		r.operand_b      = b;
		r.cond_branch    = br;
		r.is_jump        = jmp;
		r.branch_cond    = cond;
		r.pc             = cur_pc;
		r.next_pc        = npc;
		r.major_opcode   = opc;
		r.branch_offset  = off;
		r.mem_op_invalid = mem_bad;
		return r;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 6))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	function automatic exalubr_pkg::exec_req_t random_request();
		exalubr_pkg::exec_req_t r;
		r.action = ($urandom_range(0, 99) < 85) ?
			4'($urandom_range(exalubr_pkg::ACT_ADD, exalubr_pkg::ACT_SRA)) :
			4'($urandom_range(0, 15));
		r.operand_a = pick_operand();
		// equal operands now and then so eq/ne/ge see the boundary
		r.operand_b = ($urandom_range(0, 3) == 0) ? r.operand_a : pick_operand();
		r.cond_branch    = 1'($urandom_range(0, 1));
		r.is_jump        = 1'($urandom_range(0, 1));
		r.branch_cond    = 3'($urandom_range(0, 7));
		r.pc             = $urandom;
		r.next_pc        = $urandom;
		r.major_opcode   = ($urandom_range(0, 9) < 3) ? exalubr_pkg::JUMP_REG_OPCODE
		                                               : 6'($urandom);
		r.branch_offset  = 16'($urandom);
		r.mem_op_invalid = ($urandom_range(0, 19) == 0);
		return r;
	endfunction

	logic [31:0] dir_a [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_001F};
	logic [31:0] dir_b [4] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000};

	initial begin
		ledger = new();
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		action         <= exalubr_pkg::ACT_INVALID;
		operand_a      <= '0;
		operand_b      <= '0;
		cond_branch    <= 1'b0;
		is_jump        <= 1'b0;
		branch_cond    <= exalubr_pkg::BR_EQ;
		pc             <= '0;
		next_pc        <= '0;
		major_opcode   <= '0;
		branch_offset  <= '0;
		mem_op_invalid <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every action, each paired with a branch condition, extreme operands
		for (int i = 0; i < 16; i++)
			issue(instr(4'(i), dir_a[(i + 1) % 4], dir_b[(i + 1) % 4], 1'b1, 1'b0, 3'(i),
				32'h0000_1000, 32'hDEAD_BEE0, 6'd0, 16'h0004, 1'b0));
		// sra of a negative value by 31, sll by 31
		issue(instr(exalubr_pkg::ACT_SRA, 32'h0000_001F, 32'h8000_0000, 1'b0, 1'b0,
			exalubr_pkg::BR_EQ, 32'h10, 32'h0, 6'd0, 16'h0, 1'b0));
		issue(instr(exalubr_pkg::ACT_SLL, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0,
			exalubr_pkg::BR_EQ, 32'h10, 32'h0, 6'd0, 16'h0, 1'b0));
		// register-indirect jump
		issue(instr(exalubr_pkg::ACT_ADD, 32'h1, 32'h2, 1'b0, 1'b1, exalubr_pkg::BR_EQ,
			32'h0000_0400, 32'h1234_5678, exalubr_pkg::JUMP_REG_OPCODE, 16'h0010, 1'b0));
		// largest forward offset wrapping past the top, smallest backward offset
		issue(instr(exalubr_pkg::ACT_OR, 32'h5, 32'hA, 1'b0, 1'b1, exalubr_pkg::BR_EQ,
			32'hFFFF_FFF0, 32'h0, 6'd0, 16'h7FFF, 1'b0));
		issue(instr(exalubr_pkg::ACT_XOR, 32'h5, 32'hA, 1'b0, 1'b1, exalubr_pkg::BR_EQ,
			32'h0000_0000, 32'h0, 6'd0, 16'h8000, 1'b0));
		// branch wins over jump; unknown condition never taken
		issue(instr(exalubr_pkg::ACT_AND, 32'h3, 32'h3, 1'b1, 1'b1, 3'd7,
			32'h2000, 32'h0, 6'd0, 16'h0100, 1'b0));
		// unknown action still resolves a jump
		issue(instr(4'd14, 32'h9, 32'h9, 1'b0, 1'b1, exalubr_pkg::BR_EQ,
			32'h3000, 32'h0, 6'd0, 16'hFFFF, 1'b0));
		// halting requests: bad memory op over syscall, syscall, invalid
		issue(instr(exalubr_pkg::ACT_SYSCALL, 32'h1, 32'h1, 1'b1, 1'b1, exalubr_pkg::BR_EQ,
			32'h4000, 32'h8000, exalubr_pkg::JUMP_REG_OPCODE, 16'h0040, 1'b1));
		issue(instr(exalubr_pkg::ACT_SYSCALL, 32'h1, 32'h1, 1'b0, 1'b1, exalubr_pkg::BR_EQ,
			32'h4004, 32'h8000, exalubr_pkg::JUMP_REG_OPCODE, 16'h0040, 1'b0));
		issue(instr(exalubr_pkg::ACT_INVALID, 32'h1, 32'h1, 1'b1, 1'b0, exalubr_pkg::BR_EQ,
			32'h4008, 32'h8000, 6'd0, 16'h0040, 1'b0));

		// hold off until the pipe is empty before going random
		drain_results();
		@(posedge clk);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == RANDOM_REQUESTS / 2) begin
				drain_results();
				@(posedge clk);
			end
			issue(random_request());
		end

		in_valid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d requests sent (all actions, conditions, jumps, halts), %0d checked",
			requests_sent, ledger.checked);
		$display("%0d full drains, %0d mismatches, %0d results still due",
			drains, ledger.mismatches, ledger.pending());
		if (ledger.mismatches == 0 && ledger.pending() == 0)
			$display("execute_stage_alu_branch_unit: match");
		else
			$display("execute_stage_alu_branch_unit: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
design/exalubr_pkg.sv
design/execute_stage_alu_branch_unit.sv
sim/tb_execute_stage_alu_branch_unit.sv
